>>> design/ttrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttrd_pkg;

   // width of the unwrapped time and of the running overflow offset
   localparam int TimeWidth = 64;

   localparam int RecordWidth  = 32;
   localparam int ChannelWidth = 7;
   localparam int DelayWidth   = 28;
   localparam int MarkerWidth  = 12;

   // wrap constants per format
   localparam logic [TimeWidth-1:0] Wrap2chT2  = TimeWidth'(210698240);
   localparam logic [TimeWidth-1:0] Wrap2chT3  = TimeWidth'(65536);
   localparam logic [TimeWidth-1:0] WrapMcT2V1 = TimeWidth'(33552000);
   localparam logic [TimeWidth-1:0] WrapMcT2V2 = TimeWidth'(33554432);
   localparam logic [TimeWidth-1:0] WrapMcT3   = TimeWidth'(1024);

   // log2 of the counted overflow steps
   localparam int McT2Shift = 25;
   localparam int McT3Shift = 10;

   localparam logic [5:0] McOverflowChannel = 6'h3F;
   localparam logic [3:0] TwoChSpecial      = 4'hF;
   localparam logic [3:0] TwoChMaxChannel   = 4'd4;
   localparam logic [5:0] McMaxMarker       = 6'd15;

   typedef enum logic [1:0] {
      FMT_2CH_T2 = 2'd0,
      FMT_2CH_T3 = 2'd1,
      FMT_MC_T2  = 2'd2,
      FMT_MC_T3  = 2'd3
   } format_type;

   typedef enum logic [1:0] {
      KIND_PHOTON   = 2'd0,
      KIND_MARKER   = 2'd1,
      KIND_OVERFLOW = 2'd2,
      KIND_IGNORED  = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_RECORD_FORMAT  = 1'b0,
      CSR_FORMAT_VERSION = 1'b1
   } csr_index_type;

   localparam logic [1:0] VersionOne    = 2'd1;
   localparam logic [1:0] ResetVersion  = 2'd2;

   // decoded view of one record
   typedef struct packed {
      kind_type                 kind;
      logic [ChannelWidth-1:0]  channel;
      logic [TimeWidth-1:0]     addend;
      logic                     is_overflow;
      logic                     use_tag;
      logic [DelayWidth-1:0]    delay;
      logic [MarkerWidth-1:0]   marker;
      logic                     illegal;
   } decode_type;

endpackage

`default_nettype wire

>>> design/ttrd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module ttrd_decode (
   input  wire logic [ttrd_pkg::RecordWidth-1:0] record,
   input  wire logic [1:0]                       record_format,
   input  wire logic [1:0]                       format_version,
   output ttrd_pkg::decode_type                  dec
);

   logic [3:0]  ch4;
   logic [5:0]  ch6;
   logic        special;
   logic        version_one;
   logic [27:0] t28;
   logic [11:0] dt12;
   logic [15:0] ns16;
   logic [24:0] t25;
   logic [14:0] dt15;
   logic [9:0]  ns10;
   logic        mc_marker;

   assign ch4         = record[31:28];
   assign ch6         = record[30:25];
   assign special     = record[31];
   assign version_one = (format_version == ttrd_pkg::VersionOne);
   assign t28         = record[27:0];
   assign dt12        = record[27:16];
   assign ns16        = record[15:0];
   assign t25         = record[24:0];
   assign dt15        = record[24:10];
   assign ns10        = record[9:0];
   assign mc_marker   = (ch6 != 6'd0) && (ch6 <= ttrd_pkg::McMaxMarker);

   always_comb begin
      dec             = '0;
      dec.kind        = ttrd_pkg::KIND_IGNORED;
      case (ttrd_pkg::format_type'(record_format))
         ttrd_pkg::FMT_2CH_T2: begin
            if (ch4 == ttrd_pkg::TwoChSpecial) begin
               if (t28[3:0] == 4'd0) begin
                  dec.kind        = ttrd_pkg::KIND_OVERFLOW;
                  dec.is_overflow = 1'b1;
                  dec.use_tag     = 1'b1;
                  dec.addend      = ttrd_pkg::Wrap2chT2;
               end else begin
                  dec.kind    = ttrd_pkg::KIND_MARKER;
                  dec.use_tag = 1'b1;
                  dec.addend  = ttrd_pkg::TimeWidth'(t28);
                  dec.marker  = ttrd_pkg::MarkerWidth'(t28[3:0]);
               end
            end else if (ch4 > ttrd_pkg::TwoChMaxChannel) begin
               dec.illegal = 1'b1;
            end else begin
               dec.kind    = ttrd_pkg::KIND_PHOTON;
               dec.channel = ttrd_pkg::ChannelWidth'(ch4);
               dec.use_tag = 1'b1;
               dec.addend  = ttrd_pkg::TimeWidth'(t28);
               dec.delay   = t28;
            end
         end
         ttrd_pkg::FMT_2CH_T3: begin
            if (ch4 == ttrd_pkg::TwoChSpecial) begin
               if (dt12 == 12'd0) begin
                  dec.kind        = ttrd_pkg::KIND_OVERFLOW;
                  dec.is_overflow = 1'b1;
                  dec.use_tag     = 1'b1;
                  dec.addend      = ttrd_pkg::Wrap2chT3;
               end else begin
                  dec.kind    = ttrd_pkg::KIND_MARKER;
                  dec.use_tag = 1'b1;
                  dec.addend  = ttrd_pkg::TimeWidth'(ns16);
                  dec.marker  = dt12;
               end
            end else begin
               dec.illegal = (ch4 == 4'd0) || (ch4 > ttrd_pkg::TwoChMaxChannel);
               dec.kind    = ttrd_pkg::KIND_PHOTON;
               dec.channel = ttrd_pkg::ChannelWidth'(ch4);
               dec.use_tag = 1'b1;
               dec.addend  = ttrd_pkg::TimeWidth'(ns16);
               dec.delay   = ttrd_pkg::DelayWidth'(dt12);
            end
         end
         ttrd_pkg::FMT_MC_T2: begin
            if (special) begin
               if (ch6 == ttrd_pkg::McOverflowChannel) begin
                  dec.kind        = ttrd_pkg::KIND_OVERFLOW;
                  dec.is_overflow = 1'b1;
                  dec.use_tag     = 1'b1;
                  if (version_one) begin
                     dec.addend = ttrd_pkg::WrapMcT2V1;
                  end else if (t25 == 25'd0) begin
                     dec.addend = ttrd_pkg::WrapMcT2V2;
                  end else begin
                     dec.addend = ttrd_pkg::TimeWidth'(t25) << ttrd_pkg::McT2Shift;
                  end
               end else if (mc_marker) begin
                  dec.kind    = ttrd_pkg::KIND_MARKER;
                  dec.use_tag = 1'b1;
                  dec.addend  = ttrd_pkg::TimeWidth'(t25);
                  dec.marker  = ttrd_pkg::MarkerWidth'(ch6);
               end else if (ch6 == 6'd0) begin
                  // sync record
                  dec.kind    = ttrd_pkg::KIND_PHOTON;
                  dec.use_tag = 1'b1;
                  dec.addend  = ttrd_pkg::TimeWidth'(t25);
               end
            end else begin
               dec.kind    = ttrd_pkg::KIND_PHOTON;
               dec.channel = ttrd_pkg::ChannelWidth'(ch6) + ttrd_pkg::ChannelWidth'(1);
               dec.use_tag = 1'b1;
               dec.addend  = ttrd_pkg::TimeWidth'(t25);
            end
         end
         ttrd_pkg::FMT_MC_T3: begin
            if (special) begin
               if (ch6 == ttrd_pkg::McOverflowChannel) begin
                  dec.kind        = ttrd_pkg::KIND_OVERFLOW;
                  dec.is_overflow = 1'b1;
                  dec.use_tag     = 1'b1;
                  if ((ns10 == 10'd0) || version_one) begin
                     dec.addend = ttrd_pkg::WrapMcT3;
                  end else begin
                     dec.addend = ttrd_pkg::TimeWidth'(ns10) << ttrd_pkg::McT3Shift;
                  end
               end else if (mc_marker) begin
                  dec.kind    = ttrd_pkg::KIND_MARKER;
                  dec.use_tag = 1'b1;
                  dec.addend  = ttrd_pkg::TimeWidth'(ns10);
                  dec.marker  = ttrd_pkg::MarkerWidth'(ch6);
               end
            end else begin
               dec.kind    = ttrd_pkg::KIND_PHOTON;
               dec.channel = ttrd_pkg::ChannelWidth'(ch6);
               dec.use_tag = 1'b1;
               dec.addend  = ttrd_pkg::TimeWidth'(ns10);
               dec.delay   = ttrd_pkg::DelayWidth'(dt15);
            end
         end
         default: begin
            dec.kind = ttrd_pkg::KIND_IGNORED;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> design/ttrd_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module ttrd_accum (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            update,
   input  wire logic [ttrd_pkg::TimeWidth-1:0]  addend,
   output logic      [ttrd_pkg::TimeWidth-1:0]  sum
);

   logic [ttrd_pkg::TimeWidth-1:0] offset_ff;

   // one adder serves both the unwrapped tag and the offset update
   assign sum = offset_ff + addend;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (update) begin
         offset_ff <= sum;
      end
   end

endmodule

`default_nettype wire

>>> design/time_tag_record_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// time tag record decoder
// request channel: req_valid / req_ready with one 32-bit raw record per
// transaction; response channel: rsp_valid / rsp_ready with one decoded
// result (kind, channel, unwrapped time tag, delay, marker bits, illegal
// channel flag) per transaction, in record order
// csr port: csr_write_enable with csr_index 0 = record format, 1 = format
// version; write only while no transaction is in flight
// a record accepted into the input register passes through decode and a
// single 64-bit add between the input and result registers; rsp_valid
// rises when the record is written into the result register
// throughput: one record per cycle while the receiver does not stall; the
// overflow offset update is the only loop and closes through that one adder
// reset clears the overflow offset, both pipeline valids, and sets the
// format to multi-channel T3, version 2
// when the receiver stalls the result register holds and the input register
// still takes one more record; after that req_ready drops until rsp_ready
module time_tag_record_decoder (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [ttrd_pkg::RecordWidth-1:0]     req_record,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic      [1:0]                           rsp_event_kind,
   output logic      [ttrd_pkg::ChannelWidth-1:0]    rsp_channel,
   output logic      [ttrd_pkg::TimeWidth-1:0]       rsp_time_tag,
   output logic      [ttrd_pkg::DelayWidth-1:0]      rsp_delay_time,
   output logic      [ttrd_pkg::MarkerWidth-1:0]     rsp_marker_bits,
   output logic                                      rsp_illegal_channel,
   // configuration port
   input  wire logic                                 csr_write_enable,
   input  wire logic                                 csr_index,
   input  wire logic [1:0]                           csr_write_data
);

   // configuration registers
   logic [1:0] format_ff;
   logic [1:0] version_ff;

   // input register
   logic                             rec_valid_ff;
   logic [ttrd_pkg::RecordWidth-1:0] rec_ff;

   // result register
   logic                              out_valid_ff;
   ttrd_pkg::kind_type                kind_ff;
   logic [ttrd_pkg::ChannelWidth-1:0] channel_ff;
   logic [ttrd_pkg::TimeWidth-1:0]    tag_ff;
   logic [ttrd_pkg::DelayWidth-1:0]   delay_ff;
   logic [ttrd_pkg::MarkerWidth-1:0]  marker_ff;
   logic                              illegal_ff;

   ttrd_pkg::decode_type           dec;
   logic [ttrd_pkg::TimeWidth-1:0] sum;
   logic                           advance;
   logic [ttrd_pkg::TimeWidth-1:0] tag_in;

   // the record moves into the result register when that register is free
   // or is being emptied this cycle
   assign advance   = rec_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !rec_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff  <= ttrd_pkg::FMT_MC_T3;
         version_ff <= ttrd_pkg::ResetVersion;
      end else if (csr_write_enable) begin
         case (ttrd_pkg::csr_index_type'(csr_index))
            ttrd_pkg::CSR_RECORD_FORMAT:  format_ff  <= csr_write_data;
            ttrd_pkg::CSR_FORMAT_VERSION: version_ff <= csr_write_data;
            default: format_ff <= format_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rec_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         rec_ff <= req_record;
      end
   end

   ttrd_decode u_decode (
      .record         (rec_ff),
      .record_format  (format_ff),
      .format_version (version_ff),
      .dec            (dec)
   );

   // offset only moves on an overflow record that leaves the input register
   ttrd_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .update (advance && dec.is_overflow),
      .addend (dec.addend),
      .sum    (sum)
   );

   // dropped and ignored records report a zero tag
   assign tag_in = dec.use_tag ? sum : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff    <= dec.kind;
         channel_ff <= dec.channel;
         tag_ff     <= tag_in;
         delay_ff   <= dec.delay;
         marker_ff  <= dec.marker;
         illegal_ff <= dec.illegal;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_event_kind      = kind_ff;
   assign rsp_channel         = channel_ff;
   assign rsp_time_tag        = tag_ff;
   assign rsp_delay_time      = delay_ff;
   assign rsp_marker_bits     = marker_ff;
   assign rsp_illegal_channel = illegal_ff;

endmodule

`default_nettype wire
